// ===== rtl/ptzfe_pkg.sv =====
// ----------------------------------------------------------------------------
// ptzfe_pkg
// Shared types and constants of the pan-tilt command frame encoder: request
// codes, frame marker bytes, direction codes and the built-frame structure.
// ----------------------------------------------------------------------------
package ptzfe_pkg;

	// Longest frame in bytes, and the width of a byte count that can hold it.
	localparam int FRAME_MAX = 9;
	localparam int CNT_W     = $clog2(FRAME_MAX + 1);

	typedef logic [7:0] frame_byte_t;

	typedef enum logic [1:0] {
		FUNC_MOVE = 2'd0,
		FUNC_GOTO = 2'd1,
		FUNC_POLL = 2'd2,
		FUNC_LED  = 2'd3
	} func_t;

	// Frame marker and command bytes.
	localparam frame_byte_t SYNC_PELCO = 8'hff;
	localparam frame_byte_t SYNC_POS   = 8'h3a;
	localparam frame_byte_t END_POS    = 8'h5c;
	localparam frame_byte_t CMD_GOTO   = 8'h81;
	localparam frame_byte_t CMD_POLL   = 8'h82;
	localparam frame_byte_t CMD_LED    = 8'h9b;
	localparam frame_byte_t ADDR_CAM   = 8'h01;
	localparam frame_byte_t ZERO_BYTE  = 8'h00;

	// Pelco-D direction codes.
	localparam frame_byte_t DIR_STOP       = 8'h00;
	localparam frame_byte_t DIR_RIGHT      = 8'h02;
	localparam frame_byte_t DIR_LEFT       = 8'h04;
	localparam frame_byte_t DIR_RIGHT_UP   = 8'h0a;
	localparam frame_byte_t DIR_RIGHT_DOWN = 8'h12;
	localparam frame_byte_t DIR_LEFT_UP    = 8'h0c;
	localparam frame_byte_t DIR_LEFT_DOWN  = 8'h14;

	localparam logic [5:0] MAG_MAX = 6'h3f;

	// IR LED level that selects automatic mode, and the level meaning off.
	localparam logic [3:0] LED_AUTO = 4'd8;
	localparam logic [3:0] LED_OFF  = 4'd0;

	localparam logic [CNT_W-1:0] LEN_SHORT = CNT_W'(7);
	localparam logic [CNT_W-1:0] LEN_LONG  = CNT_W'(9);

	// A complete frame: byte 0 is sent first.
	typedef struct packed {
		logic [FRAME_MAX-1:0][7:0] bytes;
		logic [CNT_W-1:0]          len;
	} frame_t;

endpackage

// ===== rtl/ptzfe_frame_build.sv =====
// ----------------------------------------------------------------------------
// ptzfe_frame_build
// Builds the whole byte frame of one command request, checksum included.
// ----------------------------------------------------------------------------
module ptzfe_frame_build
	import ptzfe_pkg::*;
(
	input  logic [1:0]        func,
	input  logic signed [6:0] pan_speed,
	input  logic signed [6:0] tilt_speed,
	input  logic [15:0]       pan_position,
	input  logic [15:0]       tilt_position,
	input  logic [3:0]        led_level,
	output frame_t            frame
);

	logic [7:0]  pan_abs;
	logic [7:0]  tilt_abs;
	logic [7:0]  pan_mag;
	logic [7:0]  tilt_mag;
	logic        pan_neg;
	logic        tilt_neg;
	logic        tilt_zero;
	frame_byte_t dir_code;
	frame_byte_t led_a;
	frame_byte_t led_b;
	frame_byte_t pos_cmd;
	logic [15:0] pan_pos;
	logic [15:0] tilt_pos;

	// Magnitude of a signed speed, saturated at 63 (only -64 needs it).
	assign pan_neg  = pan_speed[6];
	assign tilt_neg = tilt_speed[6];
	assign pan_abs  = pan_neg  ? (8'd0 - {pan_speed[6],  pan_speed})
	                           : {1'b0, pan_speed};
	assign tilt_abs = tilt_neg ? (8'd0 - {tilt_speed[6], tilt_speed})
	                           : {1'b0, tilt_speed};
	assign pan_mag  = (pan_abs  > {2'b00, MAG_MAX}) ? {2'b00, MAG_MAX} : pan_abs;
	assign tilt_mag = (tilt_abs > {2'b00, MAG_MAX}) ? {2'b00, MAG_MAX} : tilt_abs;
	assign tilt_zero = (tilt_speed == 7'sd0);

	always_comb begin
		if (pan_speed == 7'sd0 && tilt_zero) begin
			dir_code = DIR_STOP;
		end else if (pan_neg) begin
			dir_code = tilt_neg ? DIR_LEFT_UP : (tilt_zero ? DIR_LEFT : DIR_LEFT_DOWN);
		end else begin
			dir_code = tilt_neg ? DIR_RIGHT_UP : (tilt_zero ? DIR_RIGHT : DIR_RIGHT_DOWN);
		end
	end

	always_comb begin
		if (led_level == LED_AUTO) begin
			led_a = ZERO_BYTE;
			led_b = ZERO_BYTE;
		end else if (led_level == LED_OFF) begin
			led_a = ZERO_BYTE;
			led_b = 8'd1;
		end else begin
			led_a = 8'd1;
			led_b = {4'd0, led_level - 4'd1};
		end
	end

	// A position poll carries zero positions.
	assign pos_cmd  = (func == FUNC_GOTO) ? CMD_GOTO : CMD_POLL;
	assign pan_pos  = (func == FUNC_GOTO) ? pan_position  : 16'd0;
	assign tilt_pos = (func == FUNC_GOTO) ? tilt_position : 16'd0;

	// Checksums are byte sums that wrap at 256, from the second byte onward.
	always_comb begin
		frame = '0;
		case (func)
			FUNC_MOVE: begin
				frame.bytes[0] = SYNC_PELCO;
				frame.bytes[1] = ADDR_CAM;
				frame.bytes[2] = ZERO_BYTE;
				frame.bytes[3] = dir_code;
				frame.bytes[4] = pan_mag;
				frame.bytes[5] = tilt_mag;
				frame.bytes[6] = ADDR_CAM + dir_code + pan_mag + tilt_mag;
				frame.len      = LEN_SHORT;
			end
			FUNC_GOTO, FUNC_POLL: begin
				frame.bytes[0] = SYNC_POS;
				frame.bytes[1] = SYNC_PELCO;
				frame.bytes[2] = pos_cmd;
				frame.bytes[3] = pan_pos[15:8];
				frame.bytes[4] = pan_pos[7:0];
				frame.bytes[5] = tilt_pos[15:8];
				frame.bytes[6] = tilt_pos[7:0];
				frame.bytes[7] = SYNC_PELCO + pos_cmd + pan_pos[15:8] + pan_pos[7:0]
				               + tilt_pos[15:8] + tilt_pos[7:0];
				frame.bytes[8] = END_POS;
				frame.len      = LEN_LONG;
			end
			default: begin
				frame.bytes[0] = SYNC_PELCO;
				frame.bytes[1] = SYNC_PELCO;
				frame.bytes[2] = ZERO_BYTE;
				frame.bytes[3] = CMD_LED;
				frame.bytes[4] = led_a;
				frame.bytes[5] = led_b;
				frame.bytes[6] = SYNC_PELCO + CMD_LED + led_a + led_b;
				frame.len      = LEN_SHORT;
			end
		endcase
	end

endmodule

// ===== rtl/ptz_command_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// ptz_command_frame_encoder
// Turns one pan-tilt command request into its serial frame, one byte per
// output request, with last_byte marking the final byte of each frame.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_ready   | func, pan_speed, tilt_speed, pan_position,
//          |                       | tilt_position, led_level
//  out     | out_valid / out_ready | out_byte, last_byte
//
//  A request produces 7 bytes (move, IR LED) or 9 bytes (go to position,
//  position poll), one per cycle while out_ready is high, as the serializer
//  shifts one byte per cycle. An accepted request passes through the holding
//  register and the serializer before its first byte reaches the output register.
//  The next request is taken into a holding frame register while the current
//  frame is still being sent, so frames follow each other with no gap.
//  Stalls on out_ready freeze the output register and a busy serializer in place.
//  Reset (arst_n low) empties the holding register, serializer and output.
// ----------------------------------------------------------------------------
module ptz_command_frame_encoder
	import ptzfe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        func,
	input  logic signed [6:0] pan_speed,
	input  logic signed [6:0] tilt_speed,
	input  logic [15:0]       pan_position,
	input  logic [15:0]       tilt_position,
	input  logic [3:0]        led_level,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              last_byte
);

	// Frame built from the request at the input.
	frame_t build_frame;

	// Stage 1: a complete frame waiting for the serializer.
	frame_t pend_frame_s1;
	logic   pend_valid_s1;

	// Stage 2: the serializer. Byte 0 of the shift register is the next byte
	// to send, and the count says how many bytes of the frame are left.
	logic [FRAME_MAX-1:0][7:0] ser_bytes_s2;
	logic [CNT_W-1:0]          ser_cnt_s2;

	// Output register.
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;

	logic in_take;
	logic out_load;
	logic ser_busy;
	logic ser_free;

	ptzfe_frame_build u_build (
		.func          (func),
		.pan_speed     (pan_speed),
		.tilt_speed    (tilt_speed),
		.pan_position  (pan_position),
		.tilt_position (tilt_position),
		.led_level     (led_level),
		.frame         (build_frame)
	);

	// The holding register takes a new request whenever it is empty; it
	// empties as soon as the serializer is free, that is when the serializer
	// is empty or is handing its final byte to the output register.
	assign in_ready = ~pend_valid_s1;
	assign in_take  = in_valid & in_ready;

	// The output register loads when it is empty or its byte is being taken.
	assign out_load = ~out_valid_q | out_ready;
	assign ser_busy = (ser_cnt_s2 != '0);

	// The serializer can take a new frame when it is empty, or when its final
	// byte moves into the output register in this cycle.
	assign ser_free = ~ser_busy | (out_load & (ser_cnt_s2 == CNT_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_s1 <= 1'b0;
		end else if (in_take) begin
			pend_valid_s1 <= 1'b1;
		end else if (ser_free) begin
			pend_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pend_frame_s1 <= build_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_cnt_s2 <= '0;
		end else if (ser_free) begin
			ser_cnt_s2 <= pend_valid_s1 ? pend_frame_s1.len : '0;
		end else if (out_load && ser_busy) begin
			ser_cnt_s2 <= ser_cnt_s2 - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ser_free) begin
			ser_bytes_s2 <= pend_frame_s1.bytes;
		end else if (out_load && ser_busy) begin
			ser_bytes_s2 <= ser_bytes_s2 >> 8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= ser_busy;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && ser_busy) begin
			out_byte_q <= ser_bytes_s2[0];
			last_q     <= (ser_cnt_s2 == CNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;

endmodule

// ===== rtl/ptzfe_checker.sv =====
// ----------------------------------------------------------------------------
// ptzfe_checker
// Port-level checks of the frame encoder: framing, frame lengths and output
// stability under back-pressure.
// ----------------------------------------------------------------------------
module ptzfe_checker
	import ptzfe_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last_byte
);

	// Number of bytes of the current frame already taken.
	logic [CNT_W-1:0] pos_q;
	logic             out_take;

	assign out_take = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (out_take) begin
			pos_q <= last_byte ? '0 : pos_q + CNT_W'(1);
		end
	end

	// A waiting byte and its last flag hold until they are taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_byte))
		else $error("output request changed while stalled");

	// Every frame opens with one of the two sync bytes.
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pos_q == '0 |-> out_byte == SYNC_PELCO || out_byte == SYNC_POS)
		else $error("frame does not start with a sync byte");

	// Frames are 7 or 9 bytes long.
	a_frame_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_byte |-> pos_q == CNT_W'(6) || pos_q == CNT_W'(8))
		else $error("frame ends at a wrong length");

	a_frame_over: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pos_q == CNT_W'(8) |-> last_byte)
		else $error("frame runs past nine bytes");

	// A nine-byte position frame closes with the end marker.
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_byte && pos_q == CNT_W'(8) |-> out_byte == END_POS)
		else $error("position frame lacks its end marker");

endmodule

bind ptz_command_frame_encoder ptzfe_checker u_ptzfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.last_byte (last_byte)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pan-tilt command frame encoder. A short table
// of directed requests, some with their frames typed in, is followed by
// random requests; every byte is checked against a typed-in frame or the predictor.
// ----------------------------------------------------------------------------
module testbench;
	import ptzfe_pkg::*;

	// A run that is still busy after this many cycles has hung.
	localparam int CYCLE_LIMIT   = 300000;
	localparam int RANDOM_COUNT  = 310;
	// Idling stops for the requests from this index on.
	localparam int QUIET_FROM    = 250;
	// The receiver's long hold-off, in cycles.
	localparam int LONG_HOLD     = 80;

	// One row of stimulus. When typed_len is nonzero, typed_frame holds the
	// whole expected frame right-aligned, byte 0 in the most significant byte.
	typedef struct packed {
		func_t             func;
		logic signed [6:0] pan;
		logic signed [6:0] tilt;
		logic [15:0]       pan_pos;
		logic [15:0]       tilt_pos;
		logic [3:0]        led;
		logic [3:0]        typed_len;
		logic [71:0]       typed_frame;
	} request_row_t;

	// One byte the block owes us, with its end-of-frame mark.
	typedef struct packed {
		frame_byte_t value;
		logic        last;
	} frame_slot_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        func = 2'd0;
	logic signed [6:0] pan_speed = 7'sd0;
	logic signed [6:0] tilt_speed = 7'sd0;
	logic [15:0]       pan_position = 16'd0;
	logic [15:0]       tilt_position = 16'd0;
	logic [3:0]        led_level = 4'd0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [7:0]        out_byte;
	logic              last_byte;

	// Bytes still owed by the block, oldest first.
	frame_slot_t  frame_bytes_due[$];
	request_row_t directed_rows[$];
	int           bad_bytes = 0;
	int           cycle_count = 0;
	// Shared between the sender and the receiver: whether random idling is
	// on, and a one-shot request for the long receiver hold-off.
	bit           idling_on = 1'b1;
	bit           long_hold_wanted = 1'b0;

	ptz_command_frame_encoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.pan_speed     (pan_speed),
		.tilt_speed    (tilt_speed),
		.pan_position  (pan_position),
		.tilt_position (tilt_position),
		.led_level     (led_level),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.last_byte     (last_byte)
	);

	always #1 clk = ~clk;

	// Magnitude of a signed speed. The most negative code has no positive
	// twin in seven bits, so it saturates to the top magnitude.
	function automatic logic [5:0] speed_magnitude(input logic signed [6:0] speed);
		logic [6:0] mag;
		if (speed < 0) begin
			mag = -speed;
		end else begin
			mag = speed;
		end
		if (mag > {1'b0, MAG_MAX}) begin
			return MAG_MAX;
		end
		return mag[5:0];
	endfunction

	// Frame predictor: builds the frame that one request must produce and
	// appends its bytes to the store of bytes due.
	function automatic void encode_request(input func_t op, input logic signed [6:0] pan,
			input logic signed [6:0] tilt, input logic [15:0] pan_pos,
			input logic [15:0] tilt_pos, input logic [3:0] led);
		frame_byte_t frame [9];
		logic [5:0]  pan_mag;
		logic [5:0]  tilt_mag;
		logic [15:0] pp;
		logic [15:0] tp;
		frame_byte_t sum;
		int          len;
		int          sum_at;
		frame_slot_t slot;
		pan_mag  = speed_magnitude(pan);
		tilt_mag = speed_magnitude(tilt);
		case (op)
			FUNC_MOVE: begin
				frame[0] = SYNC_PELCO;
				frame[1] = ADDR_CAM;
				frame[2] = ZERO_BYTE;
				// A zero pan speed falls on the right-hand side of the
				// direction table whenever the tilt is moving.
				if (pan == 0 && tilt == 0) begin
					frame[3] = DIR_STOP;
				end else if (pan < 0) begin
					frame[3] = (tilt < 0) ? DIR_LEFT_UP : (tilt > 0) ? DIR_LEFT_DOWN : DIR_LEFT;
				end else begin
					frame[3] = (tilt < 0) ? DIR_RIGHT_UP : (tilt > 0) ? DIR_RIGHT_DOWN :
						DIR_RIGHT;
				end
				frame[4] = {2'b00, pan_mag};
				frame[5] = {2'b00, tilt_mag};
				len = 7;
			end
			FUNC_GOTO, FUNC_POLL: begin
				// A poll carries zero positions whatever the position fields hold.
				pp = (op == FUNC_GOTO) ? pan_pos : 16'd0;
				tp = (op == FUNC_GOTO) ? tilt_pos : 16'd0;
				frame[0] = SYNC_POS;
				frame[1] = SYNC_PELCO;
				frame[2] = (op == FUNC_GOTO) ? CMD_GOTO : CMD_POLL;
				frame[3] = pp[15:8];
				frame[4] = pp[7:0];
				frame[5] = tp[15:8];
				frame[6] = tp[7:0];
				frame[8] = END_POS;
				len = 9;
			end
			default: begin
				frame[0] = SYNC_PELCO;
				frame[1] = SYNC_PELCO;
				frame[2] = ZERO_BYTE;
				frame[3] = CMD_LED;
				// Levels above the auto code are taken as manual levels too.
				if (led == LED_AUTO) begin
					frame[4] = 8'h00;
					frame[5] = 8'h00;
				end else if (led == LED_OFF) begin
					frame[4] = 8'h00;
					frame[5] = 8'h01;
				end else begin
					frame[4] = 8'h01;
					frame[5] = {4'h0, led - 4'd1};
				end
				len = 7;
			end
		endcase
		// The sum covers every byte after the first and before the sum itself.
		sum_at = (len == 9) ? 7 : 6;
		sum = 8'h00;
		for (int k = 1; k < sum_at; k++) begin
			sum = sum + frame[k];
		end
		frame[sum_at] = sum;
		for (int k = 0; k < len; k++) begin
			slot.value = frame[k];
			slot.last  = (k == len - 1);
			frame_bytes_due = {frame_bytes_due, slot};
		end
	endfunction

	function automatic request_row_t stim_row(input func_t op, input int pan, input int tilt,
			input int pan_pos, input int tilt_pos, input int led, input int typed_len,
			input logic [71:0] typed_frame);
		request_row_t row;
		row.func        = op;
		row.pan         = pan[6:0];
		row.tilt        = tilt[6:0];
		row.pan_pos     = pan_pos[15:0];
		row.tilt_pos    = tilt_pos[15:0];
		row.led         = led[3:0];
		row.typed_len   = typed_len[3:0];
		row.typed_frame = typed_frame;
		return row;
	endfunction

	// Appends one row to the directed table.
	function automatic void add_row(input request_row_t row);
		directed_rows = {directed_rows, row};
	endfunction

	// Offers one request, holds it until the block takes it, then records
	// the bytes it is owed: the typed-in frame if the row has one, else the
	// predictor's frame. Called right after a rising edge.
	task automatic offer_request(input request_row_t row);
		int          gap;
		frame_slot_t slot;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		func          <= row.func;
		pan_speed     <= row.pan;
		tilt_speed    <= row.tilt;
		pan_position  <= row.pan_pos;
		tilt_position <= row.tilt_pos;
		led_level     <= row.led;
		// Values read right after the edge are the ones the block sampled.
		do begin
			@(posedge clk);
		end while (!in_ready);
		if (row.typed_len != 0) begin
			for (int k = 0; k < row.typed_len; k++) begin
				slot.value = row.typed_frame[8 * (row.typed_len - 1 - k) +: 8];
				slot.last  = (k == row.typed_len - 1);
				frame_bytes_due = {frame_bytes_due, slot};
			end
		end else begin
			encode_request(row.func, row.pan, row.tilt, row.pan_pos, row.tilt_pos, row.led);
		end
	endtask

	// Sender: reset, the directed table, then random requests.
	initial begin
		request_row_t row;
		// Stop, the saturating left speed, both full diagonals, and then the
		// cases where only the sign pattern decides the direction code.
		add_row(stim_row(FUNC_MOVE, 0, 0, 0, 0, 0, 7, 56'hff010000000001));
		add_row(stim_row(FUNC_MOVE, -64, 0, 0, 0, 0, 7, 56'hff0100043f0044));
		add_row(stim_row(FUNC_MOVE, 63, 63, 0, 0, 0, 7, 56'hff0100123f3f91));
		add_row(stim_row(FUNC_MOVE, -63, -63, 0, 0, 0, 7, 56'hff01000c3f3f8b));
		add_row(stim_row(FUNC_MOVE, -1, 1, 0, 0, 0, 0, '0));
		add_row(stim_row(FUNC_MOVE, 0, 5, 0, 0, 0, 0, '0));
		add_row(stim_row(FUNC_MOVE, 0, -64, 0, 0, 0, 0, '0));
		add_row(stim_row(FUNC_MOVE, 5, 0, 0, 0, 0, 0, '0));
		add_row(stim_row(FUNC_MOVE, 63, -1, 0, 0, 0, 0, '0));
		// Fields that a move does not use are filled to show they are ignored.
		add_row(stim_row(FUNC_MOVE, -64, -64, 'hffff, 'hffff, 15, 0, '0));
		add_row(stim_row(FUNC_GOTO, 0, 0, 0, 0, 0, 9, 72'h3aff8100000000805c));
		add_row(stim_row(FUNC_GOTO, -64, 63, 'hffff, 'hffff, 15, 9,
			72'h3aff81ffffffff7c5c));
		add_row(stim_row(FUNC_GOTO, 0, 0, 'h1234, 'habcd, 0, 0, '0));
		add_row(stim_row(FUNC_POLL, 63, -64, 'hffff, 'hffff, 15, 9,
			72'h3aff8200000000815c));
		add_row(stim_row(FUNC_LED, 0, 0, 0, 0, 8, 7, 56'hffff009b00009a));
		add_row(stim_row(FUNC_LED, 0, 0, 0, 0, 0, 7, 56'hffff009b00019b));
		add_row(stim_row(FUNC_LED, 0, 0, 0, 0, 1, 0, '0));
		add_row(stim_row(FUNC_LED, 0, 0, 0, 0, 7, 0, '0));
		// Levels past the auto code are out of range but must still encode.
		add_row(stim_row(FUNC_LED, 0, 0, 0, 0, 9, 0, '0));
		add_row(stim_row(FUNC_LED, -1, -1, 'hffff, 'hffff, 15, 0, '0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			offer_request(directed_rows[i]);
		end

		for (int i = 0; i < RANDOM_COUNT; i++) begin
			// Requests 100 to 149 run with no idling at all, and so does the tail.
			idling_on = (i < 100) || (i >= 150 && i < QUIET_FROM);
			// The receiver holds off for a long stretch while requests keep
			// coming, so the holding register fills and in_ready drops.
			if (i == 20) begin
				long_hold_wanted = 1'b1;
			end
			// Once, let the block run completely dry before going on.
			if (i == 180) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (frame_bytes_due.size() != 0) @(posedge clk);
			end
			row.func     = func_t'($urandom_range(0, 3));
			row.pan      = ($urandom_range(0, 3) == 0) ? 7'sd0 : 7'($urandom_range(0, 127));
			row.tilt     = ($urandom_range(0, 3) == 0) ? 7'sd0 : 7'($urandom_range(0, 127));
			row.pan_pos  = 16'($urandom_range(0, 65535));
			row.tilt_pos = 16'($urandom_range(0, 65535));
			row.led      = 4'($urandom_range(0, 15));
			row.typed_len   = 4'd0;
			row.typed_frame = '0;
			offer_request(row);
		end
		in_valid <= 1'b0;

		while (frame_bytes_due.size() != 0) @(posedge clk);
		// Let any stray byte show up before the verdict.
		repeat (12) @(posedge clk);
		if (bad_bytes == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Receiver: out_ready drops in random bursts while idling is on, and
	// once for a long hold-off counted here.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold_wanted) begin
				long_hold_wanted = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 13);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Every byte the block hands over must match the oldest byte owed.
	always @(posedge clk) begin
		frame_slot_t owed;
		if (arst_n && out_valid && out_ready) begin
			if (frame_bytes_due.size() == 0) begin
				$display("%0t: unexpected byte %02h last %0b with nothing owed",
					$realtime, out_byte, last_byte);
				bad_bytes++;
			end else begin
				owed = frame_bytes_due.pop_front();
				if (out_byte !== owed.value || last_byte !== owed.last) begin
					$display("%0t: expected byte %02h last %0b, got byte %02h last %0b",
						$realtime, owed.value, owed.last, out_byte, last_byte);
					bad_bytes++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
